/* hdl/assert_macros.svh */
// assertion macros shared by the obb sat pipeline modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked on every rising clock edge outside reset
`define OBB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in this cycle, consequent in the next
`define OBB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/obb_sat_pkg.sv */
// types and constants for the 2d oriented box separating-axis pipeline
`default_nettype none

package obb_sat_pkg;

    // four test axes: a.x, a.y, b.x, b.y
    localparam int NUM_AXES    = 4;
    // own half extent goes from 2^-16 to 2^-44 units
    localparam int OWN_SHIFT   = 28;
    // center distance goes from 2^-30 to 2^-44 units
    localparam int DIST_SHIFT  = 14;
    // overlap goes from 2^-44 back to q16.16
    localparam int DEPTH_SHIFT = 28;

    // one box pair
    typedef struct packed {
        logic signed [31:0] a_center_x;
        logic signed [31:0] a_center_y;
        logic signed [15:0] a_axis_cos;
        logic signed [15:0] a_axis_sin;
        logic        [30:0] a_half_w;
        logic        [30:0] a_half_h;
        logic signed [31:0] b_center_x;
        logic signed [31:0] b_center_y;
        logic signed [15:0] b_axis_cos;
        logic signed [15:0] b_axis_sin;
        logic        [30:0] b_half_w;
        logic        [30:0] b_half_h;
    } pair_t;

    // one test result
    typedef struct packed {
        logic               hit;
        logic signed [15:0] push_dir_x;
        logic signed [15:0] push_dir_y;
        logic        [31:0] depth;
    } res_t;

    // per-axis extent sum, center distance, sign and axis direction, handed from the projection half
    typedef struct packed {
        logic [NUM_AXES-1:0][63:0] sum;
        logic [NUM_AXES-1:0][63:0] span;
        logic [NUM_AXES-1:0]       toward;
        logic [NUM_AXES-1:0][15:0] dir_x;
        logic [NUM_AXES-1:0][15:0] dir_y;
    } ax_test_t;

endpackage

`default_nettype wire

/* hdl/obb_obb_sat_overlap_2d_top.sv */
// throughput: one pair per cycle while res_stall is low, six register stages, 24 multipliers working in parallel
// output stall holds the last stage and every full stage behind it; bubbles are filled
// reset: asynchronous active-low, clears only the stage valid bits; no clearing pass
// top level of the 2d oriented box separating-axis test pipeline
`default_nettype none

module obb_obb_sat_overlap_2d_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               pair_valid,
    output logic                    pair_stall,
    input  wire obb_sat_pkg::pair_t pair_data,
    output logic                    res_valid,
    input  wire logic               res_stall,
    output obb_sat_pkg::res_t       res_data
);

    // transfer between the projection and selection halves
    logic                  mid_valid;
    logic                  mid_stall;
    obb_sat_pkg::ax_test_t mid_data;

    // stages 1 to 3: offsets, dots, extent products, sums
    obb_sat_proj u_proj (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (pair_valid),
        .up_stall (pair_stall),
        .up_data  (pair_data),
        .dn_valid (mid_valid),
        .dn_stall (mid_stall),
        .dn_data  (mid_data)
    );

    // stages 4 to 6: overlaps, least-overlap search, result
    obb_sat_pick u_pick (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (mid_valid),
        .up_stall (mid_stall),
        .up_data  (mid_data),
        .dn_valid (res_valid),
        .dn_stall (res_stall),
        .dn_data  (res_data)
    );

endmodule

`default_nettype wire

/* hdl/obb_sat_proj.sv */
// projection half: center offset, axis dots, extent products, sums and distances
`default_nettype none
`include "assert_macros.svh"

module obb_sat_proj (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  up_valid,
    output logic                       up_stall,
    input  wire obb_sat_pkg::pair_t    up_data,
    output logic                       dn_valid,
    input  wire logic                  dn_stall,
    output obb_sat_pkg::ax_test_t      dn_data
);

    localparam int NA = obb_sat_pkg::NUM_AXES;

    // stage enables, each stage moves when it is empty or its successor moves
    logic en1, en2, en3;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;

    // stage 1 registers
    logic signed [16:0] s1_nx_reg [NA];
    logic signed [16:0] s1_ny_reg [NA];
    logic signed [32:0] s1_dx_reg, s1_dy_reg;
    logic        [30:0] s1_ext_reg [NA];
    logic        [31:0] s1_cross_reg [2][2];

    // stage 1 next values
    logic signed [16:0] s1_nx_next [NA];
    logic signed [16:0] s1_ny_next [NA];
    logic signed [32:0] s1_dx_next, s1_dy_next;
    logic        [31:0] s1_cross_next [2][2];

    // stage 2 registers
    logic signed [50:0] s2_nd_reg [NA];
    logic        [62:0] s2_p0_reg [NA];
    logic        [62:0] s2_p1_reg [NA];
    logic        [30:0] s2_own_reg [NA];
    logic        [15:0] s2_dx_reg [NA];
    logic        [15:0] s2_dy_reg [NA];

    logic signed [50:0] s2_nd_next [NA];
    logic        [62:0] s2_p0_next [NA];
    logic        [62:0] s2_p1_next [NA];

    // stage 3 register
    obb_sat_pkg::ax_test_t s3_reg, s3_next;

    assign en3      = !s3_valid_reg || !dn_stall;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign up_stall = !en1;
    assign dn_valid = s3_valid_reg;
    assign dn_data  = s3_reg;

    // stage 1: derive the four axes, center offset and axis-axis dots
    always_comb
    begin
        logic signed [33:0] px, py, dsum;
        s1_nx_next[0] = {up_data.a_axis_cos[15], up_data.a_axis_cos};
        s1_ny_next[0] = {up_data.a_axis_sin[15], up_data.a_axis_sin};
        s1_nx_next[1] = 17'sd0 - {up_data.a_axis_sin[15], up_data.a_axis_sin};
        s1_ny_next[1] = {up_data.a_axis_cos[15], up_data.a_axis_cos};
        s1_nx_next[2] = {up_data.b_axis_cos[15], up_data.b_axis_cos};
        s1_ny_next[2] = {up_data.b_axis_sin[15], up_data.b_axis_sin};
        s1_nx_next[3] = 17'sd0 - {up_data.b_axis_sin[15], up_data.b_axis_sin};
        s1_ny_next[3] = {up_data.b_axis_cos[15], up_data.b_axis_cos};
        s1_dx_next = $signed({up_data.a_center_x[31], up_data.a_center_x})
                   - $signed({up_data.b_center_x[31], up_data.b_center_x});
        s1_dy_next = $signed({up_data.a_center_y[31], up_data.a_center_y})
                   - $signed({up_data.b_center_y[31], up_data.b_center_y});
        for (int i = 0; i < 2; i++)
        begin
            for (int j = 0; j < 2; j++)
            begin
                px   = s1_nx_next[i] * s1_nx_next[2+j];
                py   = s1_ny_next[i] * s1_ny_next[2+j];
                dsum = px + py;
                s1_cross_next[i][j] = dsum[33] ? 32'(34'sd0 - dsum) : dsum[31:0];
            end
        end
    end

    // stage 2: center offset on each axis, other box extents on each axis
    always_comb
    begin
        logic signed [49:0] mx, my;
        for (int k = 0; k < NA; k++)
        begin
            mx = s1_nx_reg[k] * s1_dx_reg;
            my = s1_ny_reg[k] * s1_dy_reg;
            s2_nd_next[k] = $signed({mx[49], mx}) + $signed({my[49], my});
        end
        for (int i = 0; i < 2; i++)
        begin
            // a axes against b extents
            s2_p0_next[i]   = s1_cross_reg[i][0] * s1_ext_reg[2];
            s2_p1_next[i]   = s1_cross_reg[i][1] * s1_ext_reg[3];
            // b axes against a extents
            s2_p0_next[i+2] = s1_cross_reg[0][i] * s1_ext_reg[0];
            s2_p1_next[i+2] = s1_cross_reg[1][i] * s1_ext_reg[1];
        end
    end

    // stage 3: extent sum and scaled center distance per axis
    always_comb
    begin
        logic [48:0] nd_mag;
        logic signed [50:0] nd_neg;
        for (int k = 0; k < NA; k++)
        begin
            nd_neg = 51'sd0 - s2_nd_reg[k];
            nd_mag = s2_nd_reg[k][50] ? nd_neg[48:0] : s2_nd_reg[k][48:0];
            s3_next.sum[k]    = {5'b0, s2_own_reg[k], {obb_sat_pkg::OWN_SHIFT{1'b0}}}
                              + {1'b0, s2_p0_reg[k]} + {1'b0, s2_p1_reg[k]};
            s3_next.span[k]   = {1'b0, nd_mag, {obb_sat_pkg::DIST_SHIFT{1'b0}}};
            s3_next.toward[k] = !s2_nd_reg[k][50] && (|s2_nd_reg[k]);
            s3_next.dir_x[k]  = s2_dx_reg[k];
            s3_next.dir_y[k]  = s2_dy_reg[k];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= up_valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_nx_reg     <= s1_nx_next;
            s1_ny_reg     <= s1_ny_next;
            s1_dx_reg     <= s1_dx_next;
            s1_dy_reg     <= s1_dy_next;
            s1_cross_reg  <= s1_cross_next;
            s1_ext_reg[0] <= up_data.a_half_w;
            s1_ext_reg[1] <= up_data.a_half_h;
            s1_ext_reg[2] <= up_data.b_half_w;
            s1_ext_reg[3] <= up_data.b_half_h;
        end
        if (en2)
        begin
            s2_nd_reg  <= s2_nd_next;
            s2_p0_reg  <= s2_p0_next;
            s2_p1_reg  <= s2_p1_next;
            s2_own_reg <= s1_ext_reg;
            for (int k = 0; k < NA; k++)
            begin
                s2_dx_reg[k] <= s1_nx_reg[k][15:0];
                s2_dy_reg[k] <= s1_ny_reg[k][15:0];
            end
        end
        if (en3)
        begin
            s3_reg <= s3_next;
        end
    end

    `OBB_ASSERT(a_stall_full, up_stall |-> &{s1_valid_reg, s2_valid_reg, s3_valid_reg}, "stall not full")
    `OBB_ASSERT_NEXT(a_s3_kept, s3_valid_reg && dn_stall, s3_valid_reg, "stalled transfer dropped")

endmodule

`default_nettype wire

/* hdl/obb_sat_pick.sv */
// selection half: overlap per axis, least-overlap search, direction and depth
`default_nettype none
`include "assert_macros.svh"

module obb_sat_pick (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  up_valid,
    output logic                       up_stall,
    input  wire obb_sat_pkg::ax_test_t up_data,
    output logic                       dn_valid,
    input  wire logic                  dn_stall,
    output obb_sat_pkg::res_t          dn_data
);

    localparam int NA = obb_sat_pkg::NUM_AXES;

    // one candidate axis in the least-overlap search
    typedef struct packed {
        logic [63:0] ov;
        logic        toward;
        logic [15:0] dir_x;
        logic [15:0] dir_y;
    } cand_t;

    logic en4, en5, en6;
    logic s4_valid_reg, s5_valid_reg, s6_valid_reg;

    cand_t s4_cand_reg [NA];
    cand_t s4_cand_next [NA];
    logic  s4_hit_reg, s4_hit_next;

    cand_t s5_cand_reg [2];
    cand_t s5_cand_next [2];
    logic  s5_hit_reg;

    obb_sat_pkg::res_t s6_reg, s6_next;

    assign en6      = !s6_valid_reg || !dn_stall;
    assign en5      = !s5_valid_reg || en6;
    assign en4      = !s4_valid_reg || en5;
    assign up_stall = !en4;
    assign dn_valid = s6_valid_reg;
    assign dn_data  = s6_reg;

    // stage 4: overlap per axis, borrow marks a separating axis
    always_comb
    begin
        logic [64:0] diff;
        logic [NA-1:0] sep;
        for (int k = 0; k < NA; k++)
        begin
            diff   = {1'b0, up_data.sum[k]} - {1'b0, up_data.span[k]};
            sep[k] = diff[64];
            s4_cand_next[k].ov     = diff[63:0];
            s4_cand_next[k].toward = up_data.toward[k];
            s4_cand_next[k].dir_x  = up_data.dir_x[k];
            s4_cand_next[k].dir_y  = up_data.dir_y[k];
        end
        s4_hit_next = ~|sep;
    end

    // stage 5: pairwise minimum, lower axis kept on ties
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            s5_cand_next[i] = (s4_cand_reg[2*i+1].ov < s4_cand_reg[2*i].ov)
                            ? s4_cand_reg[2*i+1] : s4_cand_reg[2*i];
        end
    end

    // stage 6: final minimum, orient a to b, saturate depth
    always_comb
    begin
        cand_t best;
        best = (s5_cand_reg[1].ov < s5_cand_reg[0].ov) ? s5_cand_reg[1] : s5_cand_reg[0];
        s6_next = '0;
        if (s5_hit_reg)
        begin
            s6_next.hit        = 1'b1;
            s6_next.push_dir_x = best.toward ? 16'sd0 - $signed(best.dir_x) : $signed(best.dir_x);
            s6_next.push_dir_y = best.toward ? 16'sd0 - $signed(best.dir_y) : $signed(best.dir_y);
            s6_next.depth      = (|best.ov[63:obb_sat_pkg::DEPTH_SHIFT+32])
                               ? 32'hFFFF_FFFF
                               : best.ov[obb_sat_pkg::DEPTH_SHIFT+31:obb_sat_pkg::DEPTH_SHIFT];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else
        begin
            if (en4)
            begin
                s4_valid_reg <= up_valid;
            end
            if (en5)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
            if (en6)
            begin
                s6_valid_reg <= s5_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_cand_reg <= s4_cand_next;
            s4_hit_reg  <= s4_hit_next;
        end
        if (en5)
        begin
            s5_cand_reg <= s5_cand_next;
            s5_hit_reg  <= s4_hit_reg;
        end
        if (en6)
        begin
            s6_reg <= s6_next;
        end
    end

    `OBB_ASSERT(a_miss_is_zero, (dn_valid && !dn_data.hit) |-> (dn_data == '0), "nonzero miss result")
    `OBB_ASSERT_NEXT(a_s5_kept, s5_valid_reg && !en5, s5_valid_reg, "stalled transfer dropped")

endmodule

`default_nettype wire
